// File: hdl/sha256_byte_hasher_assert.svh
// assertion macros for the byte hasher checker
`ifndef SHA256_BYTE_HASHER_ASSERT_SVH
`define SHA256_BYTE_HASHER_ASSERT_SVH

// implication checked on every clock, held off during reset
`define SHB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define SHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/shb_pkg.sv
// ----------------------------------------------------------------------------
// shb_pkg
// constants, a control type and a rotate function shared by the sha-256 byte hasher
// ----------------------------------------------------------------------------
package shb_pkg;

    localparam int ROUNDS = 64;
    localparam int BLOCK_BYTES = 64;
    localparam int DIGEST_WORDS = 8;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    typedef struct packed {
        logic start;
        logic busy;
    } t_rnd_ctl;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: hdl/shb_rounds.sv
// ----------------------------------------------------------------------------
// shb_rounds
// one sha-256 round per cycle over a 16-word schedule window
// ----------------------------------------------------------------------------
module shb_rounds
    import shb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [511:0]        i_block,
    input  logic [31:0]         i_hash [DIGEST_WORDS],
    output t_rnd_ctl            o_ctl,
    output logic [31:0]         o_hash [DIGEST_WORDS]
);

    logic        r_busy, n_busy;
    logic [5:0]  r_round;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic        r_fold;

    logic [31:0] w_new, t1, t2, s0, s1, e_sum, a_sum, ch, mj;

    always_comb begin
        s0 = ror32(r_w[1], 7) ^ ror32(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = ror32(r_w[14], 17) ^ ror32(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        e_sum = ror32(r_v[4], 6) ^ ror32(r_v[4], 11) ^ ror32(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + e_sum + ch + ROUND_K[r_round] + r_w[0];
        a_sum = ror32(r_v[0], 2) ^ ror32(r_v[0], 13) ^ ror32(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = a_sum + mj;
        n_busy = r_busy;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_round == 6'd63) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fold <= 1'b0;
            r_round <= '0;
        end else begin
            r_busy <= n_busy;
            r_fold <= r_busy && r_round == 6'd63;
            if (i_start) begin
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_block[511 - 32*i -: 32];
            end
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= i_hash[i];
                r_h[i] <= i_hash[i];
            end
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else if (r_fold) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    // busy covers the rounds and the fold cycle
    assign o_ctl.busy = r_busy || r_fold;
    assign o_ctl.start = i_start;
    assign o_hash = r_h;

endmodule

// File: hdl/sha256_byte_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_hasher
// streaming sha-256: bytes in, eight digest words out per finish request
// ----------------------------------------------------------------------------
// Byte requests may follow back to back. The 64th byte of a block is the
// exception: it holds the input while the shared round unit loads the block,
// runs 64 rounds and folds the result. A finish request shifts the padding in
// one byte per cycle up to the block end (64 minus the fill), then runs one
// compression. When 8 or fewer bytes are free, a second pass of padding over a
// whole block and a second compression follow. The eight digest words then go
// out one per cycle as they are taken. Input is not ready until the last word
// is gone. The round unit sets the throughput.
module sha256_byte_hasher
    import shb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [1:0]  s_axis_tuser,   // has_byte, finish
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word, word_index, zero fill
    output logic        m_axis_tlast    // last_word
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_COMP  = 5'b00010,
        S_PAD   = 5'b00100,
        S_PCOMP = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    logic [511:0] r_blk;
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic [63:0]  r_total;
    logic         r_fin;
    logic         r_padded;
    logic         r_last;
    logic [2:0]   r_idx;
    logic [31:0]  r_hin [DIGEST_WORDS];
    logic         r_start;
    logic         r_launched;

    logic [31:0]  rnd_hash [DIGEST_WORDS];
    t_rnd_ctl     rnd_ctl;
    logic         acc, has_b, fin_b;
    logic         comp_done;
    logic         start_req;
    logic [7:0]   pad_byte;

    assign has_b = s_axis_tuser[0];
    assign fin_b = s_axis_tuser[1];
    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = r_state == S_IDLE;
    assign comp_done = r_launched && !rnd_ctl.busy && !r_start;
    assign start_req = (r_state == S_IDLE && acc && has_b && r_fill == 6'd63) ||
                       (r_state == S_PAD && r_fill == 6'd63);

    // pad byte first, then zeros, length bytes at the tail of the last block
    always_comb begin
        if (!r_padded) begin
            pad_byte = PAD_BYTE;
        end else if (r_last && r_fill >= 6'd56) begin
            pad_byte = r_total[63:56];
        end else begin
            pad_byte = 8'd0;
        end
    end

    shb_rounds u_rounds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_block (r_blk),
        .i_hash  (r_hin),
        .o_ctl   (rnd_ctl),
        .o_hash  (rnd_hash)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (has_b && r_fill == 6'd63) begin
                        n_state = S_COMP;
                    end else if (fin_b) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_COMP: if (comp_done) n_state = r_fin ? S_PAD : S_IDLE;
            S_PAD: if (r_fill == 6'd63) n_state = S_PCOMP;
            S_PCOMP: if (comp_done) n_state = r_last ? S_OUT : S_PAD;
            S_OUT: if (m_axis_tready && r_idx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_bits <= '0;
            r_fin <= 1'b0;
            r_padded <= 1'b0;
            r_last <= 1'b0;
            r_idx <= '0;
            r_start <= 1'b0;
            r_launched <= 1'b0;
            for (int i = 0; i < DIGEST_WORDS; i++) r_hin[i] <= H_INIT[i];
        end else begin
            r_state <= n_state;
            r_start <= start_req;
            if (r_start) begin
                r_launched <= 1'b1;
            end else if (comp_done) begin
                r_launched <= 1'b0;
            end
            if (comp_done) begin
                r_hin <= rnd_hash;
            end else if (r_state == S_OUT && m_axis_tready && r_idx == 3'd7) begin
                for (int i = 0; i < DIGEST_WORDS; i++) r_hin[i] <= H_INIT[i];
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_fin <= fin_b;
                        if (has_b) begin
                            r_blk <= {r_blk[503:0], s_axis_tdata};
                            r_fill <= r_fill + 6'd1;
                        end
                    end
                end
                S_COMP: if (comp_done) r_bits <= r_bits + BLOCK_BITS;
                S_PAD: begin
                    r_blk <= {r_blk[503:0], pad_byte};
                    r_fill <= r_fill + 6'd1;
                    if (!r_padded) begin
                        // length fits behind the pad byte only below byte 56
                        r_padded <= 1'b1;
                        r_last <= r_fill < 6'd56;
                        r_total <= r_bits + {55'd0, r_fill, 3'd0};
                    end else if (r_last && r_fill >= 6'd56) begin
                        r_total <= {r_total[55:0], 8'd0};
                    end
                end
                S_PCOMP: if (comp_done && !r_last) r_last <= 1'b1;
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_bits <= '0;
                            r_padded <= 1'b0;
                            r_last <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_state == S_OUT;
    assign m_axis_tdata = {5'd0, r_idx, r_hin[r_idx]};
    assign m_axis_tlast = r_idx == 3'd7;

endmodule

// File: hdl/shb_checker.sv
// ----------------------------------------------------------------------------
// shb_checker
// port-level checks of the byte hasher
// ----------------------------------------------------------------------------
`include "sha256_byte_hasher_assert.svh"
module shb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    logic [2:0] idx, idx_inc;
    logic       fin_take, step_word;

    assign idx = m_axis_tdata[34:32];
    assign idx_inc = idx + 3'd1;
    assign fin_take = s_axis_tvalid && s_axis_tready && s_axis_tuser[1];
    assign step_word = m_axis_tvalid && m_axis_tready && !m_axis_tlast;

    `SHB_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `SHB_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (idx == 3'd7))
    `SHB_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, step_word, m_axis_tvalid && idx == $past(idx_inc))
    `SHB_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `SHB_ASSERT_NEXT(a_fin_busy, i_clk, i_rst_n, fin_take, !s_axis_tready)
endmodule

bind sha256_byte_hasher shb_checker u_shb_checker (.*);

// File: sim/sha256_byte_hasher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_byte_hasher_checker
// watches both streams, keeps its own sha-256 state and checks every digest word
// ----------------------------------------------------------------------------
module sha256_byte_hasher_checker
    import shb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [7:0]  i_req_data,
    input  logic [1:0]  i_req_user,
    input  logic        i_dig_valid,
    input  logic        i_dig_ready,
    input  logic [39:0] i_dig_data,
    input  logic        i_dig_last,
    output int          o_fail_count,
    output int          o_words_pending
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic [7:0]  msg_block [BLOCK_BYTES];
    int unsigned msg_fill;
    logic [63:0] msg_bits;
    logic [31:0] chain [DIGEST_WORDS];
    t_digest_word digest_queue [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic fold_block();
        logic [31:0] w [ROUNDS];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < ROUNDS; t++)
            w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int t = 0; t < ROUNDS; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endtask

    task automatic clear_state();
        msg_fill = 0;
        msg_bits = '0;
        for (int i = 0; i < DIGEST_WORDS; i++) chain[i] = H_INIT[i];
        for (int i = 0; i < BLOCK_BYTES; i++) msg_block[i] = '0;
    endtask

    task automatic hash_request(input logic [7:0] data, input logic has_byte,
                                input logic finish);
        logic [63:0] total;
        t_digest_word dw;
        if (has_byte) begin
            msg_block[msg_fill] = data;
            msg_fill++;
            if (msg_fill == BLOCK_BYTES) begin
                fold_block();
                msg_bits += BLOCK_BITS;
                msg_fill = 0;
            end
        end
        if (finish) begin
            total = msg_bits + 64'(msg_fill) * 8;
            msg_block[msg_fill] = PAD_BYTE;
            for (int i = msg_fill + 1; i < BLOCK_BYTES; i++) msg_block[i] = '0;
            if (msg_fill >= 56) begin
                fold_block();
                for (int i = 0; i < 56; i++) msg_block[i] = '0;
            end
            for (int i = 0; i < 8; i++) msg_block[63-i] = total[8*i +: 8];
            fold_block();
            for (int j = 0; j < DIGEST_WORDS; j++) begin
                dw.word = chain[j];
                dw.index = 3'(j);
                dw.last = (j == DIGEST_WORDS - 1);
                digest_queue.push_back(dw);
            end
            clear_state();
        end
    endtask

    initial clear_state();

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_dig_valid && i_dig_ready) begin
                if (digest_queue.size() == 0) begin
                    $error("digest word with none expected: %h", i_dig_data[31:0]);
                    errs++;
                end else begin
                    exp_w = digest_queue.pop_front();
                    if (i_dig_data[31:0] !== exp_w.word) begin
                        $error("digest_word expected %h got %h", exp_w.word, i_dig_data[31:0]);
                        errs++;
                    end
                    if (i_dig_data[34:32] !== exp_w.index) begin
                        $error("word_index expected %0d got %0d", exp_w.index,
                               i_dig_data[34:32]);
                        errs++;
                    end
                    if (i_dig_last !== exp_w.last) begin
                        $error("last_word expected %0d got %0d", exp_w.last, i_dig_last);
                        errs++;
                    end
                end
            end
            // requests are predicted after the pop so a same-edge finish queues behind
            if (i_req_valid && i_req_ready)
                hash_request(i_req_data, i_req_user[0], i_req_user[1]);
            o_fail_count <= o_fail_count + errs;
        end
        o_words_pending <= digest_queue.size();
    end

endmodule

// File: sim/tb_sha256_byte_hasher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha256_byte_hasher
// directed and random messages into the byte hasher, random stalls on both sides
// ----------------------------------------------------------------------------
module tb_sha256_byte_hasher;

    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;   // has_byte, finish
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // digest_word, word_index, zero fill
    logic        m_axis_tlast;        // last_word
    int          fail_count;
    int          words_pending;
    int          idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    sha256_byte_hasher u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    sha256_byte_hasher_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_user(s_axis_tuser),
        .i_dig_valid(m_axis_tvalid), .i_dig_ready(m_axis_tready),
        .i_dig_data(m_axis_tdata), .i_dig_last(m_axis_tlast),
        .o_fail_count(fail_count), .o_words_pending(words_pending)
    );

    // digest side: random stall per word, with calm stretches
    initial begin
        int gap;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // nothing accepted on either side for too long ends the run
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("sha256_byte_hasher verification failed");
            $finish;
        end
    end

    bit burst_mode = 1'b0;

    task automatic send_request(input logic [7:0] data, input logic has_byte,
                                input logic finish);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= {finish, has_byte};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_message(input int len, input bit byte_on_finish);
        for (int i = 0; i < len; i++)
            send_request(8'($urandom), 1'b1, 1'b0);
        send_request(8'($urandom), byte_on_finish, 1'b1);
    endtask

    initial begin
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty message, idle request, extremes of the byte
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b0);
        send_request(8'h5a, 1'b0, 1'b0);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b0, 1'b1);
        // hold off until all digests are out
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (words_pending == 0);
        // padding spills into a second block at 56..63 bytes, block edge at 64
        burst_mode = 1'b1;
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
        burst_mode = 1'b0;
        // random short messages
        for (int m = 0; m < 8; m++) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            len = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0)
                send_request(8'($urandom), 1'b0, 1'b0);
            send_message(len, $urandom_range(0, 1));
        end
        burst_mode = 1'b0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (words_pending == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("sha256_byte_hasher verification clean");
        else
            $display("sha256_byte_hasher verification failed");
        $finish;
    end

endmodule
